// File: sv/amc_pkg.sv
package amc_pkg;

  // Command codes of an input transaction
  localparam logic [2:0] CMD_TICK      = 3'd0;
  localparam logic [2:0] CMD_STICK     = 3'd1;
  localparam logic [2:0] CMD_WAIT      = 3'd2;
  localparam logic [2:0] CMD_CONN_ERR  = 3'd3;
  localparam logic [2:0] CMD_GYRO_ERR  = 3'd4;

  // Arming modes
  localparam logic [2:0] MODE_DISARMED = 3'd0;
  localparam logic [2:0] MODE_ARMED    = 3'd1;
  localparam logic [2:0] MODE_WAIT     = 3'd2;
  localparam logic [2:0] MODE_ESC_CAL  = 3'd3;
  localparam logic [2:0] MODE_CONN_ERR = 3'd4;
  localparam logic [2:0] MODE_GYRO_ERR = 3'd5;

  // Configuration register indexes
  localparam logic CFG_LOW_THR  = 1'b0;
  localparam logic CFG_HIGH_THR = 1'b1;

  localparam logic [11:0] LOW_THR_RESET  = 12'd1100;
  localparam logic [11:0] HIGH_THR_RESET = 12'd1900;

  // Blink periods in milliseconds
  localparam logic [9:0] PERIOD_FAST  = 10'd100;
  localparam logic [9:0] PERIOD_MID   = 10'd500;
  localparam logic [9:0] PERIOD_WAIT  = 10'd900;
  localparam logic [9:0] PERIOD_SLOW  = 10'd1000;
  localparam logic [9:0] PERIOD_NONE  = 10'd0;

  localparam logic [10:0] ELAPSED_MAX = 11'd2047;

  typedef struct packed {
    logic [2:0]  command;
    logic [11:0] roll_width;
    logic [11:0] pitch_width;
    logic [11:0] throttle_width;
    logic [11:0] yaw_width;
  } in_item_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       error_led;
    logic       debug_led;
    logic       right_led;
    logic       left_led;
  } out_item_t;

endpackage

// File: sv/arming_mode_controller_with_led_blink.sv
// Arming mode controller with LED blink timing. Each input transaction is a
// millisecond tick, a stick sample or a mode event, and each one returns
// exactly one result transaction with the current arming mode and the four
// held LED levels. An accepted transaction lands in an input register, the
// mode and blink update is combinational compare-and-select logic, and
// the result sits in an output register; a new transaction is taken every
// cycle, limited only by back-pressure on the result channel. The thresholds
// are written through the configuration channel, which is always ready, and
// should only be written while no transaction is in flight.
module arming_mode_controller_with_led_blink import amc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic      cfg_index_i,
  input  logic [11:0] cfg_data_i
);

  logic        s1_valid_q;
  in_item_t    s1_item_q;
  logic        out_valid_q;
  out_item_t   out_item_q, out_item_d;
  logic        s1_adv;

  logic [11:0] low_thr_q, high_thr_q;
  logic [2:0]  mode_q, mode_d;
  logic        debug_phase_q, debug_phase_d;
  logic        error_phase_q, error_phase_d;
  logic [10:0] elapsed_q, elapsed_d, elapsed_inc;
  logic [9:0]  period_q, period_d;
  logic [3:0]  leds_q, leds_d;   // {left, right, debug, error}

  // Advance the input stage when the result register is free or draining
  assign s1_adv      = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !s1_valid_q || s1_adv;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;
  assign cfg_ready_o = 1'b1;

  // Write threshold registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_thr_q  <= LOW_THR_RESET;
      high_thr_q <= HIGH_THR_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_LOW_THR:  low_thr_q  <= cfg_data_i;
        CFG_HIGH_THR: high_thr_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Compute the next mode and blink state for the staged transaction
  always_comb begin
    logic r_lo, r_hi, p_lo, p_hi, t_lo, t_hi, y_lo, y_hi, any_zero, ph;
    r_lo = s1_item_q.roll_width < low_thr_q;
    r_hi = s1_item_q.roll_width > high_thr_q;
    p_lo = s1_item_q.pitch_width < low_thr_q;
    p_hi = s1_item_q.pitch_width > high_thr_q;
    t_lo = s1_item_q.throttle_width < low_thr_q;
    t_hi = s1_item_q.throttle_width > high_thr_q;
    y_lo = s1_item_q.yaw_width < low_thr_q;
    y_hi = s1_item_q.yaw_width > high_thr_q;
    any_zero = (s1_item_q.roll_width == '0) || (s1_item_q.pitch_width == '0) ||
               (s1_item_q.throttle_width == '0) || (s1_item_q.yaw_width == '0);

    mode_d        = mode_q;
    debug_phase_d = debug_phase_q;
    error_phase_d = error_phase_q;
    elapsed_d     = elapsed_q;
    period_d      = period_q;
    leds_d        = leds_q;
    elapsed_inc   = (elapsed_q == ELAPSED_MAX) ? elapsed_q : elapsed_q + 11'd1;
    ph            = !debug_phase_q;

    case (s1_item_q.command)
      CMD_TICK: begin
        elapsed_d = elapsed_inc;
        if (elapsed_inc > {1'b0, period_q}) begin
          debug_phase_d = ph;
          error_phase_d = !error_phase_q;
          elapsed_d     = '0;
          case (mode_q)
            MODE_ARMED: begin
              period_d = ph ? PERIOD_FAST : PERIOD_SLOW;
              leds_d   = {!ph, !ph, ph, leds_q[0]};
            end
            MODE_DISARMED: begin
              period_d = PERIOD_MID;
              leds_d   = {!ph, ph, ph, leds_q[0]};
            end
            MODE_WAIT: begin
              period_d = ph ? PERIOD_WAIT : PERIOD_FAST;
              leds_d   = {1'b0, 1'b0, ph, leds_q[0]};
            end
            MODE_ESC_CAL: begin
              period_d = PERIOD_NONE;
              leds_d   = {1'b0, 1'b0, ph, leds_q[0]};
            end
            MODE_CONN_ERR: begin
              period_d = PERIOD_FAST;
              leds_d   = {3'b000, !error_phase_q};
            end
            MODE_GYRO_ERR: begin
              period_d = PERIOD_MID;
              leds_d   = {3'b000, !error_phase_q};
            end
            default: ;
          endcase
        end
      end
      CMD_STICK: begin
        if (mode_q == MODE_DISARMED) begin
          if (t_lo && y_lo && r_lo && p_hi) begin
            mode_d = MODE_ARMED;
          end else if (t_hi && y_lo) begin
            mode_d = MODE_ESC_CAL;
          end
        end else if (mode_q == MODE_WAIT) begin
          if (!any_zero && r_hi && p_lo && t_hi && y_hi) begin
            mode_d = MODE_DISARMED;
          end
        end else if (t_lo && y_hi) begin
          mode_d = MODE_DISARMED;
        end
      end
      CMD_WAIT:     mode_d = MODE_WAIT;
      CMD_CONN_ERR: mode_d = MODE_CONN_ERR;
      CMD_GYRO_ERR: mode_d = MODE_GYRO_ERR;
      default: ;
    endcase

    out_item_d.mode      = mode_d;
    out_item_d.error_led = leds_d[0];
    out_item_d.debug_led = leds_d[1];
    out_item_d.right_led = leds_d[2];
    out_item_d.left_led  = leds_d[3];
  end

  // Hold the input stage, state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      mode_q        <= MODE_DISARMED;
      debug_phase_q <= 1'b0;
      error_phase_q <= 1'b0;
      elapsed_q     <= '0;
      period_q      <= '0;
      leds_q        <= '0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (s1_adv) begin
        out_valid_q   <= 1'b1;
        mode_q        <= mode_d;
        debug_phase_q <= debug_phase_d;
        error_phase_q <= error_phase_d;
        elapsed_q     <= elapsed_d;
        period_q      <= period_d;
        leds_q        <= leds_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Capture payloads without reset
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_item_q <= in_item_i;
    end
    if (s1_adv) begin
      out_item_q <= out_item_d;
    end
  end

  // The timer never runs past the current period
  a_elapsed_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    elapsed_q <= {1'b0, period_q})
    else $error("elapsed count above blink period");

  a_period_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    period_q == PERIOD_NONE || period_q == PERIOD_FAST || period_q == PERIOD_MID ||
    period_q == PERIOD_WAIT || period_q == PERIOD_SLOW)
    else $error("illegal blink period");

  a_stage_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |=> s1_valid_q)
    else $error("staged transaction dropped");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> out_valid_q)
    else $error("result register not loaded");

  a_mode_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q <= MODE_GYRO_ERR)
    else $error("mode out of range");

endmodule
